### rtl/invert_matrix_3x3_assert.svh
// Assertion macros used by invert_matrix_3x3.sv. They sample on clk and stay quiet during reset.
`ifndef INVERT_MATRIX_3X3_ASSERT_SVH
`define INVERT_MATRIX_3X3_ASSERT_SVH
`ifndef SYNTHESIS
`define IMA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed in invert_matrix_3x3");
`define IMA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed in invert_matrix_3x3");
`else
`define IMA_ASSERT_IMPL(label, ante, cons)
`define IMA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/ima_pkg.sv
package ima_pkg;

	// Field formats.
	localparam int IN_W     = 16;
	localparam int IN_FRAC  = 12;
	localparam int OUT_W    = 32;
	localparam int OUT_FRAC = 16;

	// Internal widths of the cofactor and determinant arithmetic.
	localparam int PROD_W = 2 * IN_W;
	localparam int COF_W  = PROD_W + 1;
	localparam int CM_W   = PROD_W;
	localparam int DP_W   = IN_W + COF_W;
	localparam int DET_W  = DP_W + 2;
	localparam int DM_W   = DET_W - 1;

	// Divider geometry: the numerator is the cofactor magnitude scaled up by SHIFT bits.
	localparam int SHIFT    = IN_FRAC + OUT_FRAC;
	localparam int NUM_W    = CM_W + SHIFT;
	localparam int Q_W      = OUT_W;
	localparam int HI_W     = NUM_W - Q_W;
	localparam int STEP_PER = 2;
	localparam int DIV_STG  = Q_W / STEP_PER;

	// Pipeline depth: front end, divider entry, divider steps, output register.
	localparam int FRONT_STG = 4;
	localparam int N_STG     = FRONT_STG + 1 + DIV_STG + 1;

	typedef logic signed [IN_W-1:0] elem_t;
	typedef logic [CM_W-1:0] cmag_t;
	typedef logic [DM_W-1:0] dmag_t;

	typedef struct packed {
		logic [Q_W-1:0] q;
		logic           ovf;
		logic           neg;
		logic           zero;
	} lane_res_t;

	// Cofactor k is sign * (a[X]*a[Y] - a[Z]*a[V]), k in row-major output order.
	localparam int COF_X [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
	localparam int COF_Y [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
	localparam int COF_Z [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
	localparam int COF_V [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
	localparam logic [8:0] COF_NEG = 9'b010101010;

endpackage

### rtl/ima_if.sv
interface ima_in_if import ima_pkg::*; ();
	logic  valid;
	logic  ready;
	elem_t a00, a01, a02, a10, a11, a12, a20, a21, a22;

	modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
	modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface ima_out_if import ima_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
	logic                    singular;
	logic                    saturated;

	modport source(output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
		inv22, singular, saturated, input ready);
	modport sink(input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
		inv22, singular, saturated, output ready);
endinterface

### rtl/ima_front.sv
module ima_front import ima_pkg::*; (
	input  logic                 clk,
	input  logic [FRONT_STG-1:0] en,
	input  elem_t                a [9],
	output dmag_t                dm,
	output cmag_t                cm [9],
	output logic [8:0]           neg
);

	logic signed [PROD_W-1:0] p1_s1 [9];
	logic signed [PROD_W-1:0] p2_s1 [9];
	elem_t                    a_s1 [3];
	elem_t                    a_s2 [3];
	logic signed [COF_W-1:0]  cof_d [9];
	logic signed [COF_W-1:0]  cof_s2 [9];
	logic signed [COF_W-1:0]  cof_s3 [9];
	logic signed [DP_W-1:0]   dp_s3 [3];
	logic signed [DET_W-1:0]  det;
	logic [DET_W-1:0]         det_abs;
	logic [COF_W-1:0]         cof_abs [9];
	dmag_t                    dm_s4;
	cmag_t                    cm_s4 [9];
	logic [8:0]               neg_s4;

	// Stage 1: the eighteen two-entry products.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < 9; k++) begin
				p1_s1[k] <= a[COF_X[k]] * a[COF_Y[k]];
				p2_s1[k] <= a[COF_Z[k]] * a[COF_V[k]];
			end
			for (int j = 0; j < 3; j++) begin
				a_s1[j] <= a[j];
			end
		end
	end

	// Stage 2: signed cofactors of the adjugate.
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			cof_d[k] = COF_W'(p1_s1[k]) - COF_W'(p2_s1[k]);
			if (COF_NEG[k]) begin
				cof_d[k] = -cof_d[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cof_s2 <= cof_d;
			a_s2   <= a_s1;
		end
	end

	// Stage 3: first-row terms of the determinant.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int j = 0; j < 3; j++) begin
				dp_s3[j] <= a_s2[j] * cof_s2[3 * j];
			end
			cof_s3 <= cof_s2;
		end
	end

	// Stage 4: determinant, magnitudes and quotient signs.
	always_comb begin
		det     = DET_W'(dp_s3[0]) + DET_W'(dp_s3[1]) + DET_W'(dp_s3[2]);
		det_abs = det[DET_W-1] ? -det : det;
		for (int k = 0; k < 9; k++) begin
			cof_abs[k] = cof_s3[k][COF_W-1] ? -cof_s3[k] : cof_s3[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			dm_s4 <= det_abs[DM_W-1:0];
			for (int k = 0; k < 9; k++) begin
				cm_s4[k]  <= cof_abs[k][CM_W-1:0];
				neg_s4[k] <= (cof_s3[k][COF_W-1] ^ det[DET_W-1]) && (cof_s3[k] != '0);
			end
		end
	end

	assign dm  = dm_s4;
	assign cm  = cm_s4;
	assign neg = neg_s4;

endmodule

### rtl/ima_div_lane.sv
module ima_div_lane import ima_pkg::*; (
	input  logic               clk,
	input  logic [DIV_STG:0]   en,
	input  cmag_t              cm,
	input  dmag_t              dm,
	input  logic               neg,
	output lane_res_t          res
);

	logic [NUM_W-1:0] num;
	logic [HI_W-1:0]  hi;
	logic             ovf;

	logic [DM_W-1:0] rem_s  [DIV_STG+1];
	logic [Q_W-1:0]  low_s  [DIV_STG+1];
	logic [Q_W-1:0]  q_s    [DIV_STG+1];
	dmag_t           dm_s   [DIV_STG+1];
	logic            neg_s  [DIV_STG+1];
	logic            ovf_s  [DIV_STG+1];
	logic            zero_s [DIV_STG+1];

	// Entry: a quotient of 2^Q_W or more is caught from the high numerator bits alone.
	assign num = {cm, {SHIFT{1'b0}}};
	assign hi  = num[NUM_W-1:Q_W];
	assign ovf = {{(DM_W-HI_W){1'b0}}, hi} >= dm;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0]  <= {{(DM_W-HI_W){1'b0}}, hi};
			low_s[0]  <= num[Q_W-1:0];
			q_s[0]    <= '0;
			dm_s[0]   <= dm;
			neg_s[0]  <= neg;
			ovf_s[0]  <= ovf;
			zero_s[0] <= (dm == '0);
		end
	end

	// Restoring division, STEP_PER quotient bits per stage.
	for (genvar g = 1; g <= DIV_STG; g++) begin : g_stage
		logic [DM_W-1:0] rem_n;
		logic [Q_W-1:0]  low_n;
		logic [Q_W-1:0]  q_n;

		always_comb begin
			logic [DM_W:0] t;
			logic [DM_W:0] d;
			rem_n = rem_s[g-1];
			low_n = low_s[g-1];
			q_n   = q_s[g-1];
			for (int st = 0; st < STEP_PER; st++) begin
				t     = {rem_n, low_n[Q_W-1]};
				low_n = {low_n[Q_W-2:0], 1'b0};
				d     = t - {1'b0, dm_s[g-1]};
				if (t >= {1'b0, dm_s[g-1]}) begin
					rem_n = d[DM_W-1:0];
					q_n   = {q_n[Q_W-2:0], 1'b1};
				end else begin
					rem_n = t[DM_W-1:0];
					q_n   = {q_n[Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				rem_s[g]  <= rem_n;
				low_s[g]  <= low_n;
				q_s[g]    <= q_n;
				dm_s[g]   <= dm_s[g-1];
				neg_s[g]  <= neg_s[g-1];
				ovf_s[g]  <= ovf_s[g-1];
				zero_s[g] <= zero_s[g-1];
			end
		end
	end

	assign res = '{q: q_s[DIV_STG], ovf: ovf_s[DIV_STG], neg: neg_s[DIV_STG],
		zero: zero_s[DIV_STG]};

endmodule

### rtl/ima_merge.sv
module ima_merge import ima_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  lane_res_t               lr [9],
	output logic signed [OUT_W-1:0] inv [9],
	output logic                    singular,
	output logic                    saturated
);

	localparam logic [OUT_W:0] LIM_POS = {2'b00, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W:0] LIM_NEG = {2'b01, {(OUT_W-1){1'b0}}};

	logic [OUT_W:0]          lim [9];
	logic [OUT_W:0]          mag [9];
	logic [OUT_W:0]          sv [9];
	logic [8:0]              sat;
	logic signed [OUT_W-1:0] val [9];
	logic signed [OUT_W-1:0] inv_q [9];
	logic                    singular_q;
	logic                    saturated_q;

	// Clip each quotient to its signed limit, apply the sign, zero a singular matrix.
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			lim[k] = lr[k].neg ? LIM_NEG : LIM_POS;
			sat[k] = (lr[k].ovf || ({1'b0, lr[k].q} > lim[k])) && !lr[k].zero;
			mag[k] = (lr[k].ovf || ({1'b0, lr[k].q} > lim[k])) ? lim[k] : {1'b0, lr[k].q};
			sv[k]  = lr[k].neg ? -mag[k] : mag[k];
			val[k] = lr[k].zero ? '0 : sv[k][OUT_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			inv_q       <= val;
			singular_q  <= lr[0].zero;
			saturated_q <= |sat;
		end
	end

	assign inv       = inv_q;
	assign singular  = singular_q;
	assign saturated = saturated_q;

endmodule

### rtl/invert_matrix_3x3.sv
// 3x3 matrix inverse by adjugate and determinant.
// Input channel src carries one matrix per item: nine signed Q4.12 entries a00..a22.
// Output channel dst carries one result per item: nine signed Q16.16 inverse entries
// inv00..inv22, rounded toward zero and clipped to 32 bits, plus the flags singular
// (determinant zero, entries zero) and saturated (some entry was clipped).
// Items pass from acceptance on src to dst through the front-end stages of products,
// cofactors and determinant, a divider entry stage, the restoring division stages at
// two quotient bits per stage in nine parallel lanes, and the output register that
// merges the lanes and applies sign and clipping. Throughput is one item per cycle
// while dst does not stall; every stage is a full register stage.
// Reset clears the valid bit of every stage, so the block comes up empty.
// When dst stalls, items move forward into empty stages and src stays ready until
// all 22 stages hold an item; nothing is dropped or duplicated.
`include "invert_matrix_3x3_assert.svh"

module invert_matrix_3x3 import ima_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ima_in_if.sink      src,
	ima_out_if.source   dst
);

	logic [N_STG-1:0] v_q;
	logic [N_STG-1:0] en;
	elem_t            a [9];
	dmag_t            dm;
	cmag_t            cm [9];
	logic [8:0]       neg;
	lane_res_t        lr [9];
	logic signed [OUT_W-1:0] inv [9];

	// A stage loads when it is empty or the stage after it moves.
	always_comb begin
		en[N_STG-1] = !v_q[N_STG-1] || dst.ready;
		for (int i = N_STG - 2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= src.valid;
			end
			for (int i = 1; i < N_STG; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	assign src.ready = en[0];
	assign dst.valid = v_q[N_STG-1];

	assign a[0] = src.a00;
	assign a[1] = src.a01;
	assign a[2] = src.a02;
	assign a[3] = src.a10;
	assign a[4] = src.a11;
	assign a[5] = src.a12;
	assign a[6] = src.a20;
	assign a[7] = src.a21;
	assign a[8] = src.a22;

	// Cofactors and determinant.
	ima_front u_front (
		.clk (clk),
		.en  (en[FRONT_STG-1:0]),
		.a   (a),
		.dm  (dm),
		.cm  (cm),
		.neg (neg)
	);

	// One divider lane per inverse entry.
	for (genvar k = 0; k < 9; k++) begin : g_lane
		ima_div_lane u_lane (
			.clk (clk),
			.en  (en[FRONT_STG+DIV_STG:FRONT_STG]),
			.cm  (cm[k]),
			.dm  (dm),
			.neg (neg[k]),
			.res (lr[k])
		);
	end

	// Sign, clipping and flags.
	ima_merge u_merge (
		.clk       (clk),
		.en        (en[N_STG-1]),
		.lr        (lr),
		.inv       (inv),
		.singular  (dst.singular),
		.saturated (dst.saturated)
	);

	assign dst.inv00 = inv[0];
	assign dst.inv01 = inv[1];
	assign dst.inv02 = inv[2];
	assign dst.inv10 = inv[3];
	assign dst.inv11 = inv[4];
	assign dst.inv12 = inv[5];
	assign dst.inv20 = inv[6];
	assign dst.inv21 = inv[7];
	assign dst.inv22 = inv[8];

	`IMA_ASSERT_IMPL(a_ready_when_room, !(&v_q), src.ready)
	`IMA_ASSERT_IMPL(a_singular_clean, dst.valid && dst.singular, !dst.saturated && dst.inv00 == '0 && dst.inv11 == '0 && dst.inv22 == '0)
	`IMA_ASSERT_NEXT(a_fill_grows, src.valid && src.ready && !(dst.valid && dst.ready), $countones(v_q) == $past($countones(v_q)) + 1)

endmodule
